[src/arpc_pkg.sv]
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the address-resolution cache and responder.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int LEN_W   = 11;
    localparam int OPC_W   = 16;
    localparam int ACT_W   = 2;
    localparam int KIND_W  = 2;
    localparam int OPO_W   = 2;
    localparam int CFG_IDX_W = 2;

    // stream widths, padded to whole bytes
    localparam int S_FIELDS_W = LEN_W + OPC_W + MAC_W + 3 * IP_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = MAC_W + OPO_W + MAC_W + IP_W + 1 + MAC_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // input actions
    localparam logic [ACT_W-1:0] ACT_RX      = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOOKUP  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REQUEST = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_REPLY   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd2;

    // outgoing opcodes
    localparam logic [OPO_W-1:0] OPO_NONE    = 2'd0;
    localparam logic [OPO_W-1:0] OPO_REQUEST = 2'd1;
    localparam logic [OPO_W-1:0] OPO_REPLY   = 2'd2;

    // incoming request opcode
    localparam logic [OPC_W-1:0] OPC_IN_REQUEST = 16'h0001;

    localparam logic [LEN_W-1:0] MIN_ARP_LEN = 11'd28;
    localparam logic [MAC_W-1:0] BCAST_MAC   = 48'hFFFF_FFFF_FFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OUR_IP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUR_MAC = 2'd1;

    // token that walks the cell chain
    typedef struct packed {
        logic             active;
        logic             is_store;
        logic             done;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } token_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [MAC_W-1:0]  dest_mac;
        logic [OPO_W-1:0]  opcode;
        logic [MAC_W-1:0]  target_mac;
        logic [IP_W-1:0]   tgt_ip;
        logic              hit;
        logic [MAC_W-1:0]  found_mac;
    } result_t;

endpackage

`default_nettype wire

[src/arpc_cell.sv]
// ----------------------------------------------------------------------------
// arpc_cell
// One cache entry; updates or searches itself as the token passes by.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_cell (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire arpc_pkg::token_t tok_in,
    output arpc_pkg::token_t     tok_out
);

    logic                         valid_reg, valid_next;
    logic [arpc_pkg::IP_W-1:0]    ip_reg, ip_next;
    logic [arpc_pkg::MAC_W-1:0]   mac_reg, mac_next;
    arpc_pkg::token_t             tok_reg, tok_next;
    logic                         match;

    assign match = valid_reg && (ip_reg == tok_in.ip);

    always_comb begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        ip_next    = ip_reg;
        mac_next   = mac_reg;
        if (tok_in.active && !tok_in.done) begin
            if (tok_in.is_store) begin
                // first free slot or same address takes the sender
                if (!valid_reg || match) begin
                    valid_next    = 1'b1;
                    ip_next       = tok_in.ip;
                    mac_next      = tok_in.mac;
                    tok_next.done = 1'b1;
                end
            end else if (match) begin
                tok_next.done = 1'b1;
                tok_next.mac  = mac_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        ip_reg  <= ip_next;
        mac_reg <= mac_next;
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

[src/arp_cache_responder_unit.sv]
// ----------------------------------------------------------------------------
// arp_cache_responder_unit
// ARP cache of IPv4 to MAC entries with request responder and request issue.
// ----------------------------------------------------------------------------
// The cache is a row of TABLE_ENTRIES cells, one entry each. A received packet
// (length 28 or more) or a lookup launches a token that moves one cell per
// clock; the first free or matching cell stores the sender, the first valid
// matching cell answers a lookup. The walk of the token down the chain sets
// the timing: a lookup answer passes from the launch register through each
// cell register into the staging register and then the output register. The
// next request is taken once the token has left the chain and the staging
// register is empty. A send request passes its result from the staging
// register to the output register; a short packet or an undefined action
// holds neither the chain nor the staging register. A reply to a request
// aimed at our_ip is queued at acceptance while the store walks the chain.
// One result may wait in the output register while the next request is
// taken. Valid bits clear at reset, no clearing pass is run, and entries
// never age. The sender fields of outgoing packets are the our_ip and our_mac
// registers themselves. cfg_ready is always high; index 0 is our_ip, index 1
// is our_mac, other indexes are ignored.
`default_nettype none

module arp_cache_responder_unit #(
    parameter int TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write channel
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [arpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [arpc_pkg::MAC_W-1:0]        cfg_data,
    // request channel
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    // packet_length, arp_opcode_in, sender_mac_in, sender_ip_in,
    // target_ip_in, query_ip, zero pad
    input  wire logic [arpc_pkg::S_TDATA_W-1:0]    s_tdata,
    // action
    input  wire logic [arpc_pkg::ACT_W-1:0]        s_tuser,
    // result channel
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    // dest_mac, arp_opcode_out, target_mac_out, target_ip_out, hit,
    // found_mac, zero pad
    output      logic [arpc_pkg::M_TDATA_W-1:0]    m_tdata,
    // result_kind
    output      logic [arpc_pkg::KIND_W-1:0]       m_tuser
);

    // request fields
    logic [arpc_pkg::ACT_W-1:0] in_action;
    logic [arpc_pkg::LEN_W-1:0] in_len;
    logic [arpc_pkg::OPC_W-1:0] in_opcode;
    logic [arpc_pkg::MAC_W-1:0] in_smac;
    logic [arpc_pkg::IP_W-1:0]  in_sip;
    logic [arpc_pkg::IP_W-1:0]  in_tip;
    logic [arpc_pkg::IP_W-1:0]  in_qip;

    assign in_action = s_tuser;
    assign in_len    = s_tdata[10:0];
    assign in_opcode = s_tdata[26:11];
    assign in_smac   = s_tdata[74:27];
    assign in_sip    = s_tdata[106:75];
    assign in_tip    = s_tdata[138:107];
    assign in_qip    = s_tdata[170:139];

    // configuration registers
    logic [arpc_pkg::IP_W-1:0]  our_ip_reg;
    logic [arpc_pkg::MAC_W-1:0] our_mac_reg;

    assign cfg_ready = 1'b1;

    // control and data registers
    arpc_pkg::token_t  launch_reg, launch_next;
    arpc_pkg::result_t res_reg, res_next;
    arpc_pkg::result_t m_res_reg, m_res_next;
    logic              res_valid_reg, res_valid_next;
    logic              m_valid_reg, m_valid_next;
    logic              chain_busy_reg, chain_busy_next;

    // token taps between cells
    arpc_pkg::token_t        chain [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES:0]  act_vec;
    arpc_pkg::token_t        tail;

    logic accept;
    logic rx_ok;
    logic do_reply;
    logic do_launch;
    logic move;

    assign accept    = s_tvalid && s_tready;
    // one request in the chain and one result staged at a time
    assign s_tready  = !chain_busy_reg && !res_valid_reg;
    assign rx_ok     = (in_action == arpc_pkg::ACT_RX) && (in_len >= arpc_pkg::MIN_ARP_LEN);
    assign do_reply  = rx_ok && (in_opcode == arpc_pkg::OPC_IN_REQUEST)
                       && (in_tip == our_ip_reg);
    assign do_launch = accept && (rx_ok || (in_action == arpc_pkg::ACT_LOOKUP));
    assign tail      = chain[TABLE_ENTRIES];
    // staged result moves on when the output register frees up
    assign move      = res_valid_reg && (!m_valid_reg || m_tready);

    assign chain[0]   = launch_reg;
    assign act_vec[0] = launch_reg.active;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        arpc_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (chain[g]),
            .tok_out (chain[g+1])
        );
        assign act_vec[g+1] = chain[g+1].active;
    end

    always_comb begin
        launch_next        = launch_reg;
        launch_next.active = 1'b0;
        if (do_launch) begin
            launch_next.active   = 1'b1;
            launch_next.is_store = rx_ok;
            launch_next.done     = 1'b0;
            launch_next.ip       = rx_ok ? in_sip : in_qip;
            // lookup starts with zero so a miss reports zero
            launch_next.mac      = rx_ok ? in_smac : '0;
        end
    end

    always_comb begin
        chain_busy_next = chain_busy_reg;
        if (tail.active) begin
            chain_busy_next = 1'b0;
        end
        if (do_launch) begin
            chain_busy_next = 1'b1;
        end
    end

    always_comb begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (move) begin
            res_valid_next = 1'b0;
        end
        if (accept && do_reply) begin
            res_valid_next      = 1'b1;
            res_next            = '0;
            res_next.kind       = arpc_pkg::KIND_REPLY;
            res_next.dest_mac   = in_smac;
            res_next.opcode     = arpc_pkg::OPO_REPLY;
            res_next.target_mac = in_smac;
            res_next.tgt_ip     = in_sip;
        end else if (accept && (in_action == arpc_pkg::ACT_REQUEST)) begin
            res_valid_next     = 1'b1;
            res_next           = '0;
            res_next.kind      = arpc_pkg::KIND_REQUEST;
            res_next.dest_mac  = arpc_pkg::BCAST_MAC;
            res_next.opcode    = arpc_pkg::OPO_REQUEST;
            res_next.tgt_ip    = in_qip;
        end else if (tail.active && !tail.is_store) begin
            // lookup answer at the end of the chain
            res_valid_next     = 1'b1;
            res_next           = '0;
            res_next.kind      = arpc_pkg::KIND_LOOKUP;
            res_next.opcode    = arpc_pkg::OPO_NONE;
            res_next.hit       = tail.done;
            res_next.found_mac = tail.done ? tail.mac : '0;
        end
    end

    always_comb begin
        m_res_next   = m_res_reg;
        m_valid_next = m_valid_reg;
        if (move) begin
            m_valid_next = 1'b1;
            m_res_next   = res_reg;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            our_ip_reg     <= '0;
            our_mac_reg    <= '0;
            launch_reg     <= '0;
            chain_busy_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    arpc_pkg::CFG_OUR_IP: begin
                        our_ip_reg <= cfg_data[arpc_pkg::IP_W-1:0];
                    end
                    arpc_pkg::CFG_OUR_MAC: begin
                        our_mac_reg <= cfg_data;
                    end
                    default: begin
                        our_ip_reg <= our_ip_reg;
                    end
                endcase
            end
            launch_reg     <= launch_next;
            chain_busy_reg <= chain_busy_next;
            res_valid_reg  <= res_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg   <= res_next;
        m_res_reg <= m_res_next;
    end

    // our_mac is the sender field of outgoing packets, held for the frame
    // builder and not repeated in the result
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.kind;
    assign m_tdata  = {{(arpc_pkg::M_TDATA_W - arpc_pkg::M_FIELDS_W){1'b0}},
                       m_res_reg.found_mac,
                       m_res_reg.hit,
                       m_res_reg.tgt_ip,
                       m_res_reg.target_mac,
                       m_res_reg.opcode,
                       m_res_reg.dest_mac};

    // at most one token in flight along the chain
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(act_vec) <= 1)
        else $error("more than one token in the cell chain");

    // a token leaving the chain belongs to a busy walk
    a_tail_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        tail.active |-> chain_busy_reg)
        else $error("token left the chain while idle");

    // a launched store or lookup keeps the block busy next cycle
    a_launch_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        do_launch |=> (chain_busy_reg && launch_reg.active))
        else $error("launch did not enter the chain");

    // a hit always carries a lookup kind
    a_hit_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && res_reg.hit) |-> (res_reg.kind == arpc_pkg::KIND_LOOKUP))
        else $error("hit flag on a non-lookup result");

    // our_mac stays fixed while a request is in progress unless a configuration write lands
    a_mac_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (chain_busy_reg && !(cfg_valid && cfg_ready)) |=> $stable(our_mac_reg))
        else $error("our_mac changed without a write");

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ARP cache and responder unit. A clocked driver
// feeds received packets, lookups and send requests from a queue. A cycle
// predictor keeps its own copy of the cache and the station registers and
// queues the result each accepted request should produce. A monitor compares
// every result field by field. Phases vary the station address and the
// amount of source idling and sink stalling.
// ----------------------------------------------------------------------------

module testbench;

    localparam int ACT_W     = arpc_pkg::ACT_W;
    localparam int LEN_W     = arpc_pkg::LEN_W;
    localparam int OPC_W     = arpc_pkg::OPC_W;
    localparam int MAC_W     = arpc_pkg::MAC_W;
    localparam int IP_W      = arpc_pkg::IP_W;
    localparam int OPO_W     = arpc_pkg::OPO_W;
    localparam int KIND_W    = arpc_pkg::KIND_W;
    localparam int CFG_IDX_W = arpc_pkg::CFG_IDX_W;
    localparam int S_TDATA_W = arpc_pkg::S_TDATA_W;
    localparam int M_TDATA_W = arpc_pkg::M_TDATA_W;

    localparam int CACHE_DEPTH   = arpc_pkg::TABLE_ENTRIES_DEF;
    localparam int SETTLE_CYCLES = CACHE_DEPTH + 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int POOL_SIZE     = 24;
    localparam int S_PAD         = arpc_pkg::S_TDATA_W - arpc_pkg::S_FIELDS_W;

    // action code with no meaning, must be dropped
    localparam logic [ACT_W-1:0]     ACT_NONE     = 2'd3;
    // incoming reply opcode, caches the sender but never answered
    localparam logic [OPC_W-1:0]     OPC_IN_REPLY = 16'h0002;
    // register indexes outside the map, writes are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B  = 2'd3;

    // result field offsets inside m_tdata
    localparam int M_OPC_LSB  = MAC_W;
    localparam int M_TMAC_LSB = M_OPC_LSB + OPO_W;
    localparam int M_TIP_LSB  = M_TMAC_LSB + MAC_W;
    localparam int M_HIT_BIT  = M_TIP_LSB + IP_W;
    localparam int M_FMAC_LSB = M_HIT_BIT + 1;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [LEN_W-1:0] plen;
        logic [OPC_W-1:0] opcode;
        logic [MAC_W-1:0] smac;
        logic [IP_W-1:0]  sip;
        logic [IP_W-1:0]  tip;
        logic [IP_W-1:0]  qip;
    } arp_req_t;

    // clock, reset and block ports
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [MAC_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [ACT_W-1:0]     s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]    m_tuser;

    // stimulus side
    arp_req_t      req_queue[$];
    arp_req_t      cur_req;
    logic          s_fire = 1'b0;
    int            src_idle_pct  = 0;
    int            snk_stall_pct = 0;
    int            hold_req  = 0;
    int            hold_ack  = 0;
    int            hold_left = 0;
    logic [IP_W-1:0] gen_ip;
    logic [IP_W-1:0] ip_pool [POOL_SIZE];

    // predictor state
    logic [IP_W-1:0]   stn_ip  = '0;
    logic              cache_valid [CACHE_DEPTH];
    logic [IP_W-1:0]   cache_ip    [CACHE_DEPTH];
    logic [MAC_W-1:0]  cache_mac   [CACHE_DEPTH];
    arpc_pkg::result_t expected_results[$];
    int                mismatches = 0;

    arp_cache_responder_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // runaway guard, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // cache update and answer for one request, returns 1 when a result is due
    function automatic bit predict_arp(input arp_req_t r, output arpc_pkg::result_t res);
        int i;
        bit done;
        res  = '0;
        done = 1'b0;
        case (r.action)
            arpc_pkg::ACT_RX: begin
                // runt packets leave the cache alone
                if (r.plen < arpc_pkg::MIN_ARP_LEN)
                    return 1'b0;
                // first free slot or the slot already holding this sender
                for (i = 0; i < CACHE_DEPTH; i++) begin
                    if (!done && (!cache_valid[i] || cache_ip[i] == r.sip)) begin
                        cache_valid[i] = 1'b1;
                        cache_ip[i]    = r.sip;
                        cache_mac[i]   = r.smac;
                        done           = 1'b1;
                    end
                end
                // only a request aimed at us gets answered
                if (r.opcode == arpc_pkg::OPC_IN_REQUEST && r.tip == stn_ip) begin
                    res.kind       = arpc_pkg::KIND_REPLY;
                    res.dest_mac   = r.smac;
                    res.opcode     = arpc_pkg::OPO_REPLY;
                    res.target_mac = r.smac;
                    res.tgt_ip     = r.sip;
                    return 1'b1;
                end
                return 1'b0;
            end
            arpc_pkg::ACT_LOOKUP: begin
                res.kind   = arpc_pkg::KIND_LOOKUP;
                res.opcode = arpc_pkg::OPO_NONE;
                for (i = 0; i < CACHE_DEPTH; i++) begin
                    if (!done && cache_valid[i] && cache_ip[i] == r.qip) begin
                        res.hit       = 1'b1;
                        res.found_mac = cache_mac[i];
                        done          = 1'b1;
                    end
                end
                return 1'b1;
            end
            arpc_pkg::ACT_REQUEST: begin
                res.kind   = arpc_pkg::KIND_REQUEST;
                res.dest_mac = arpc_pkg::BCAST_MAC;
                res.opcode = arpc_pkg::OPO_REQUEST;
                res.tgt_ip = r.qip;
                return 1'b1;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] exp_v,
                                          input logic [63:0] got_v);
        if (got_v !== exp_v) begin
            mismatches++;
            $display("%0t: %s expected %h got %h", $time, name, exp_v, got_v);
        end
    endfunction

    function automatic arp_req_t mk_req(input logic [ACT_W-1:0] action,
                                        input logic [LEN_W-1:0] plen,
                                        input logic [OPC_W-1:0] opcode,
                                        input logic [MAC_W-1:0] smac,
                                        input logic [IP_W-1:0] sip,
                                        input logic [IP_W-1:0] tip,
                                        input logic [IP_W-1:0] qip);
        arp_req_t r;
        r.action = action;
        r.plen   = plen;
        r.opcode = opcode;
        r.smac   = smac;
        r.sip    = sip;
        r.tip    = tip;
        r.qip    = qip;
        return r;
    endfunction

    // mostly well-formed traffic over a small address pool so the cache fills,
    // gets hit, gets refreshed and then overflows
    function automatic arp_req_t random_req();
        arp_req_t r;
        int pick;
        pick     = $urandom_range(99);
        r.action = ACT_NONE;
        r.plen   = LEN_W'($urandom);
        r.opcode = OPC_W'($urandom);
        r.smac   = {16'($urandom), 32'($urandom)};
        r.sip    = $urandom;
        r.tip    = $urandom;
        r.qip    = $urandom;
        if (pick < 45) begin
            r.action = arpc_pkg::ACT_RX;
            pick = $urandom_range(9);
            if (pick == 0)
                r.plen = LEN_W'($urandom_range(arpc_pkg::MIN_ARP_LEN - 1));
            else if (pick == 1)
                r.plen = arpc_pkg::MIN_ARP_LEN;
            else
                r.plen = LEN_W'($urandom_range(2047, arpc_pkg::MIN_ARP_LEN));
            pick = $urandom_range(9);
            if (pick < 6)
                r.opcode = arpc_pkg::OPC_IN_REQUEST;
            else if (pick == 6)
                r.opcode = OPC_IN_REPLY;
            if ($urandom_range(99) < 80)
                r.sip = ip_pool[$urandom_range(POOL_SIZE - 1)];
            if ($urandom_range(1) == 0)
                r.tip = gen_ip;
            else if ($urandom_range(1) == 0)
                r.tip = ip_pool[$urandom_range(POOL_SIZE - 1)];
        end else if (pick < 80) begin
            r.action = arpc_pkg::ACT_LOOKUP;
            if ($urandom_range(99) < 75)
                r.qip = ip_pool[$urandom_range(POOL_SIZE - 1)];
        end else if (pick < 95) begin
            r.action = arpc_pkg::ACT_REQUEST;
        end
        return r;
    endfunction

    // request driver: new request only once the previous one is taken
    always @(negedge aclk) begin : request_drive
        arp_req_t nxt;
        if (aresetn && (!s_tvalid || s_fire)) begin
            if (req_queue.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                nxt = req_queue.pop_front();
                cur_req  <= nxt;
                s_tdata  <= {{S_PAD{1'b0}}, nxt.qip, nxt.tip, nxt.sip, nxt.smac,
                             nxt.opcode, nxt.plen};
                s_tuser  <= nxt.action;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        // sink side, forced low during a long hold-off
        m_tready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
    end

    // long sink hold-off, counted here so the source keeps pushing meanwhile
    always @(negedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_left <= HOLD_CYCLES;
            hold_ack  <= hold_req;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // accepted requests and register writes feed the predictor, results are checked
    always @(posedge aclk) begin : result_check
        arpc_pkg::result_t res;
        arpc_pkg::result_t exp_r;
        s_fire <= aresetn && s_tvalid && s_tready;
        if (!aresetn) begin
            for (int i = 0; i < CACHE_DEPTH; i++)
                cache_valid[i] = 1'b0;
            stn_ip = '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    arpc_pkg::CFG_OUR_IP: begin
                        stn_ip = cfg_data[IP_W-1:0];
                    end
                    arpc_pkg::CFG_OUR_MAC: begin
                        // station MAC never shows in a result
                    end
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (predict_arp(cur_req, res))
                    expected_results.push_back(res);
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none got kind %h data %h",
                             $time, m_tuser, m_tdata);
                end else begin
                    exp_r = expected_results.pop_front();
                    compare_field("result_kind", 64'(exp_r.kind), 64'(m_tuser));
                    compare_field("dest_mac", 64'(exp_r.dest_mac),
                                  64'(m_tdata[MAC_W-1:0]));
                    compare_field("arp_opcode_out", 64'(exp_r.opcode),
                                  64'(m_tdata[M_OPC_LSB +: OPO_W]));
                    compare_field("target_mac_out", 64'(exp_r.target_mac),
                                  64'(m_tdata[M_TMAC_LSB +: MAC_W]));
                    compare_field("target_ip_out", 64'(exp_r.tgt_ip),
                                  64'(m_tdata[M_TIP_LSB +: IP_W]));
                    compare_field("hit", 64'(exp_r.hit), 64'(m_tdata[M_HIT_BIT]));
                    compare_field("found_mac", 64'(exp_r.found_mac),
                                  64'(m_tdata[M_FMAC_LSB +: MAC_W]));
                end
            end
        end
    end

    // station registers, only while the block is idle
    task automatic program_station(input logic [MAC_W-1:0] ip_word,
                                   input logic [MAC_W-1:0] mac_word,
                                   input bit with_spares);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [MAC_W-1:0]     val [4];
        int n;
        idx = '{arpc_pkg::CFG_OUR_IP, CFG_SPARE_A, arpc_pkg::CFG_OUR_MAC, CFG_SPARE_B};
        val = '{ip_word, '1, mac_word, {16'($urandom), 32'($urandom)}};
        for (n = 0; n < 4; n++) begin
            if (with_spares || idx[n] == arpc_pkg::CFG_OUR_IP
                || idx[n] == arpc_pkg::CFG_OUR_MAC) begin
                @(negedge aclk);
                cfg_valid <= 1'b1;
                cfg_index <= idx[n];
                cfg_data  <= val[n];
                do @(posedge aclk); while (!(cfg_valid && cfg_ready));
            end
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
        gen_ip = ip_word[IP_W-1:0];
    endtask

    // all requests taken, all results seen, then room for a store still walking
    task automatic settle();
        do @(negedge aclk);
        while (req_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic run_phase(input int src_pct, input int snk_pct, input int count,
                             input bit squeeze);
        arp_req_t r;
        int made;
        @(posedge aclk);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        if (squeeze)
            hold_req++;
        made = 0;
        while (made < count) begin
            r = random_req();
            req_queue.push_back(r);
            made++;
        end
        settle();
    endtask

    initial begin : stimulus
        logic [IP_W-1:0]  ip_a;
        logic [MAC_W-1:0] mac_a;
        logic [MAC_W-1:0] mac_b;
        for (int i = 0; i < POOL_SIZE; i++)
            ip_pool[i] = $urandom;
        ip_a  = 32'h0A00_0001;
        mac_a = 48'h0211_2233_4455;
        mac_b = 48'h02AA_BBCC_DDEE;
        gen_ip = '0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // upper data bits of the address write must be dropped
        program_station({16'hA5A5, 32'hC0A8_0001}, 48'h0200_0000_0001, 1'b1);

        // directed: empty cache, runt packet, store, refresh, extremes
        req_queue.push_back(mk_req(arpc_pkg::ACT_LOOKUP, '0, '0, '0, '0, '0, '0));
        req_queue.push_back(mk_req(arpc_pkg::ACT_RX, arpc_pkg::MIN_ARP_LEN - 1,
                                   arpc_pkg::OPC_IN_REQUEST, mac_a, ip_a, gen_ip, '0));
        req_queue.push_back(mk_req(arpc_pkg::ACT_LOOKUP, '0, '0, '0, '0, '0, ip_a));
        req_queue.push_back(mk_req(arpc_pkg::ACT_RX, arpc_pkg::MIN_ARP_LEN,
                                   arpc_pkg::OPC_IN_REQUEST, mac_a, ip_a, gen_ip, '0));
        req_queue.push_back(mk_req(arpc_pkg::ACT_LOOKUP, '0, '0, '0, '0, '0, ip_a));
        req_queue.push_back(mk_req(arpc_pkg::ACT_RX, '1, OPC_IN_REPLY, '1, '1, gen_ip, '1));
        req_queue.push_back(mk_req(arpc_pkg::ACT_RX, 11'd60, arpc_pkg::OPC_IN_REQUEST,
                                   '0, '0, ~gen_ip, '0));
        req_queue.push_back(mk_req(arpc_pkg::ACT_RX, arpc_pkg::MIN_ARP_LEN, '1, mac_b,
                                   ip_a + 1, gen_ip, '0));
        // same sender again, new MAC lands in the same slot
        req_queue.push_back(mk_req(arpc_pkg::ACT_RX, 11'd46, arpc_pkg::OPC_IN_REQUEST,
                                   mac_b, ip_a, gen_ip, '0));
        req_queue.push_back(mk_req(arpc_pkg::ACT_LOOKUP, '1, '1, '1, '1, '1, ip_a));
        req_queue.push_back(mk_req(arpc_pkg::ACT_LOOKUP, '0, '0, '0, '0, '0, '0));
        req_queue.push_back(mk_req(arpc_pkg::ACT_LOOKUP, '0, '0, '0, '0, '0, '1));
        req_queue.push_back(mk_req(arpc_pkg::ACT_LOOKUP, '0, '0, '0, '0, '0, ip_a + 1));
        req_queue.push_back(mk_req(arpc_pkg::ACT_REQUEST, '0, '0, '0, '0, '0, '0));
        req_queue.push_back(mk_req(arpc_pkg::ACT_REQUEST, '1, '1, '1, '1, '1, '1));
        // undefined action with every field busy
        req_queue.push_back(mk_req(ACT_NONE, '1, arpc_pkg::OPC_IN_REQUEST, '1,
                                   32'h0A00_0009, gen_ip, '1));
        req_queue.push_back(mk_req(arpc_pkg::ACT_LOOKUP, '0, '0, '0, '0, '0,
                                   32'h0A00_0009));
        settle();

        // full rate, with a long sink hold-off to back up the request side
        run_phase(0, 0, 160, 1'b1);

        program_station('1, '1, 1'b1);
        run_phase(64, 0, 160, 1'b0);

        program_station('0, '0, 1'b1);
        run_phase(0, 64, 160, 1'b0);

        program_station({16'($urandom), ip_pool[0]}, {16'($urandom), 32'($urandom)}, 1'b0);
        run_phase(18, 18, 170, 1'b0);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
src/arpc_pkg.sv
src/arpc_cell.sv
src/arp_cache_responder_unit.sv
bench/testbench.sv
